[sv/rbs_pkg.sv]
package rbs_pkg;

    localparam int MAX_RECORDS = 32;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    localparam int TAG_W  = 8;
    localparam int AGE_W  = 7;
    localparam int NAME_W = 64;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [AGE_W-1:0]  age;
        logic [NAME_W-1:0] name;
    } rec_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS_INIT,
        ST_PASS_LOAD,
        ST_RD,
        ST_CMP,
        ST_TAIL,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

endpackage

[sv/rbs_in_if.sv]
interface rbs_in_if;
    logic                        valid;
    logic                        ready;
    logic [rbs_pkg::TAG_W-1:0]   record_tag;
    logic [rbs_pkg::AGE_W-1:0]   age_key;
    logic [rbs_pkg::NAME_W-1:0]  name_key;
    logic                        last_record;

    modport source
    (
        output valid, record_tag, age_key, name_key, last_record,
        input  ready
    );

    modport sink
    (
        input  valid, record_tag, age_key, name_key, last_record,
        output ready
    );
endinterface

[sv/rbs_out_if.sv]
interface rbs_out_if;
    logic                        valid;
    logic                        ready;
    logic [rbs_pkg::TAG_W-1:0]   out_tag;
    logic [rbs_pkg::AGE_W-1:0]   out_age;
    logic [rbs_pkg::NAME_W-1:0]  out_name;
    logic                        out_last;

    modport source
    (
        output valid, out_tag, out_age, out_name, out_last,
        input  ready
    );

    modport sink
    (
        input  valid, out_tag, out_age, out_name, out_last,
        output ready
    );
endinterface

[sv/record_bubble_sort_by_key.sv]
// Load: one record request per cycle while ready; a request marked last starts the sort
// (or, with under two records, the emit). Sort: each pass reads record 0 (PASS_INIT,
// PASS_LOAD), then RD/CMP do one memory read and one write per compare; TAIL stores
// the pass maximum. Emit: EMIT_RD and EMIT_OUT per record; ready stays low until done.
// Reset (rst_n low, asynchronous): sequencer to load, count and sort_by_name cleared;
// the record memory is not cleared.
module record_bubble_sort_by_key
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    rbs_in_if.sink       rec,
    rbs_out_if.source    sorted
);

    localparam int IDX_W = rbs_pkg::IDX_W;
    localparam int CNT_W = rbs_pkg::CNT_W;

    rbs_pkg::rec_t   mem [rbs_pkg::MAX_RECORDS];
    rbs_pkg::rec_t   rd_data_reg;
    rbs_pkg::rec_t   cur_reg, cur_next;
    rbs_pkg::rec_t   wr_data;
    rbs_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] lim_reg, lim_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] e_reg, e_next;
    logic             mode_reg, mode_next;
    logic             sort_by_name_reg, sort_by_name_next;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_en;
    logic             has_room;
    logic [CNT_W-1:0] n_after;
    logic [CNT_W-1:0] lim_dec;
    logic             gt;
    logic             pass_done;
    logic             emit_last;
    logic             in_acc;

    assign in_acc    = rec.valid && rec.ready;
    assign has_room  = count_reg < CNT_W'(rbs_pkg::MAX_RECORDS);
    assign n_after   = has_room ? count_reg + CNT_W'(1) : count_reg;
    assign lim_dec   = lim_reg - CNT_W'(1);
    assign gt        = mode_reg ? (cur_reg.name > rd_data_reg.name)
                                : (cur_reg.age > rd_data_reg.age);
    assign pass_done = (CNT_W'(j_reg) + CNT_W'(2)) == lim_reg;
    assign emit_last = (CNT_W'(e_reg) + CNT_W'(1)) == total_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rbs_pkg::ST_LOAD:
            begin
                if (rec.valid && rec.last_record)
                begin
                    state_next = (n_after >= CNT_W'(2)) ? rbs_pkg::ST_PASS_INIT
                                                        : rbs_pkg::ST_EMIT_RD;
                end
            end
            rbs_pkg::ST_PASS_INIT: state_next = rbs_pkg::ST_PASS_LOAD;
            rbs_pkg::ST_PASS_LOAD: state_next = rbs_pkg::ST_RD;
            rbs_pkg::ST_RD:        state_next = rbs_pkg::ST_CMP;
            rbs_pkg::ST_CMP:
                state_next = pass_done ? rbs_pkg::ST_TAIL : rbs_pkg::ST_RD;
            rbs_pkg::ST_TAIL:
                state_next = (lim_dec >= CNT_W'(2)) ? rbs_pkg::ST_PASS_INIT
                                                    : rbs_pkg::ST_EMIT_RD;
            rbs_pkg::ST_EMIT_RD:   state_next = rbs_pkg::ST_EMIT_OUT;
            rbs_pkg::ST_EMIT_OUT:
            begin
                if (sorted.ready)
                begin
                    state_next = emit_last ? rbs_pkg::ST_LOAD : rbs_pkg::ST_EMIT_RD;
                end
            end
            default:               state_next = rbs_pkg::ST_LOAD;
        endcase
    end

    always_comb
    begin
        rec.ready       = 1'b0;
        sorted.valid    = 1'b0;
        sorted.out_tag  = rd_data_reg.tag;
        sorted.out_age  = rd_data_reg.age;
        sorted.out_name = rd_data_reg.name;
        sorted.out_last = emit_last;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = j_reg;
        wr_data         = cur_reg;
        unique case (state_reg)
            rbs_pkg::ST_LOAD:
            begin
                rec.ready    = 1'b1;
                wr_en        = rec.valid && has_room;
                wr_addr      = count_reg[IDX_W-1:0];
                wr_data.tag  = rec.record_tag;
                wr_data.age  = rec.age_key;
                wr_data.name = rec.name_key;
            end
            rbs_pkg::ST_PASS_INIT: rd_addr = '0;
            rbs_pkg::ST_PASS_LOAD: rd_addr = '0;
            rbs_pkg::ST_RD:        rd_addr = j_reg + IDX_W'(1);
            rbs_pkg::ST_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = gt ? rd_data_reg : cur_reg;
            end
            rbs_pkg::ST_TAIL:
            begin
                wr_en   = 1'b1;
                wr_addr = lim_dec[IDX_W-1:0];
                wr_data = cur_reg;
            end
            rbs_pkg::ST_EMIT_RD:   rd_addr = e_reg;
            rbs_pkg::ST_EMIT_OUT:
            begin
                rd_addr      = e_reg;
                sorted.valid = 1'b1;
            end
            default:               rd_addr = '0;
        endcase
    end

    always_comb
    begin
        count_next        = count_reg;
        total_next        = total_reg;
        lim_next          = lim_reg;
        j_next            = j_reg;
        e_next            = e_reg;
        cur_next          = cur_reg;
        mode_next         = mode_reg;
        sort_by_name_next = cfg_we ? cfg_wdata : sort_by_name_reg;
        case (state_reg)
            rbs_pkg::ST_LOAD:
            begin
                if (in_acc)
                begin
                    count_next = n_after;
                    if (rec.last_record)
                    begin
                        count_next = '0;
                        total_next = n_after;
                        lim_next   = n_after;
                        mode_next  = sort_by_name_reg;
                        e_next     = '0;
                    end
                end
            end
            rbs_pkg::ST_PASS_INIT: j_next   = '0;
            rbs_pkg::ST_PASS_LOAD: cur_next = rd_data_reg;
            rbs_pkg::ST_CMP:
            begin
                cur_next = gt ? cur_reg : rd_data_reg;
                j_next   = j_reg + IDX_W'(1);
            end
            rbs_pkg::ST_TAIL:      lim_next = lim_dec;
            rbs_pkg::ST_EMIT_OUT:
            begin
                if (sorted.ready && !emit_last)
                begin
                    e_next = e_reg + IDX_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= rbs_pkg::ST_LOAD;
            count_reg        <= '0;
            total_reg        <= '0;
            lim_reg          <= '0;
            j_reg            <= '0;
            e_reg            <= '0;
            mode_reg         <= 1'b0;
            sort_by_name_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            total_reg        <= total_next;
            lim_reg          <= lim_next;
            j_reg            <= j_next;
            e_reg            <= e_next;
            mode_reg         <= mode_next;
            sort_by_name_reg <= sort_by_name_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(sorted.valid && rec.ready))
        else $error("input ready while a sorted record is pending");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(rbs_pkg::MAX_RECORDS))
        else $error("record count beyond capacity");

    a_cmp_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rbs_pkg::ST_CMP) |-> (lim_reg >= CNT_W'(2) && lim_reg <= total_reg))
        else $error("compare outside the active pass");

    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (sorted.valid && sorted.ready && sorted.out_last) |=> (rec.ready && count_reg == '0))
        else $error("not back to load after the final sorted record");

endmodule

[verif/record_bubble_sort_by_key_checker.sv]
module record_bubble_sort_by_key_checker
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    rbs_in_if    rec_mon,
    rbs_out_if   sorted_mon,
    output int   errors,
    output int   pending
);

    typedef struct packed {
        rbs_pkg::rec_t rec;
        logic          last;
    } sorted_rec_t;

    rbs_pkg::rec_t held [rbs_pkg::MAX_RECORDS];
    int            held_n;
    logic          by_name;
    int            fails;
    sorted_rec_t   sorted_due [$];

    always @(posedge clk or negedge rst_n)
    begin : watch
        rbs_pkg::rec_t tmp;
        sorted_rec_t   want;
        bit            greater;
        int            i;
        int            j;
        if (!rst_n)
        begin
            held_n = 0;
            by_name = 1'b0;
            fails = 0;
            sorted_due.delete();
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                by_name = cfg_wdata;

            if (sorted_mon.valid && sorted_mon.ready)
            begin
                if (sorted_due.size() == 0)
                begin
                    $error("sorted request with none expected: out_tag %0h", sorted_mon.out_tag);
                    fails++;
                end
                else
                begin
                    want = sorted_due.pop_front();
                    if (sorted_mon.out_tag !== want.rec.tag)
                    begin
                        $error("out_tag expected %0h actual %0h", want.rec.tag,
                               sorted_mon.out_tag);
                        fails++;
                    end
                    if (sorted_mon.out_age !== want.rec.age)
                    begin
                        $error("out_age expected %0d actual %0d", want.rec.age,
                               sorted_mon.out_age);
                        fails++;
                    end
                    if (sorted_mon.out_name !== want.rec.name)
                    begin
                        $error("out_name expected %016h actual %016h", want.rec.name,
                               sorted_mon.out_name);
                        fails++;
                    end
                    if (sorted_mon.out_last !== want.last)
                    begin
                        $error("out_last expected %0b actual %0b", want.last,
                               sorted_mon.out_last);
                        fails++;
                    end
                end
            end

            if (rec_mon.valid && rec_mon.ready)
            begin
                if (held_n < rbs_pkg::MAX_RECORDS)
                begin
                    held[held_n].tag = rec_mon.record_tag;
                    held[held_n].age = rec_mon.age_key;
                    held[held_n].name = rec_mon.name_key;
                    held_n++;
                end
                if (rec_mon.last_record)
                begin
                    for (i = 0; i + 1 < held_n; i++)
                    begin
                        for (j = 0; j + 1 < held_n - i; j++)
                        begin
                            greater = by_name ? (held[j].name > held[j + 1].name)
                                              : (held[j].age > held[j + 1].age);
                            if (greater)
                            begin
                                tmp = held[j];
                                held[j] = held[j + 1];
                                held[j + 1] = tmp;
                            end
                        end
                    end
                    for (i = 0; i < held_n; i++)
                    begin
                        want.rec = held[i];
                        want.last = (i == held_n - 1);
                        sorted_due.push_back(want);
                    end
                    held_n = 0;
                end
            end

            errors <= fails;
            pending <= sorted_due.size();
        end
    end

endmodule

[verif/record_bubble_sort_by_key_tb.sv]
module record_bubble_sort_by_key_tb;

    localparam bit BY_AGE  = 1'b0;
    localparam bit BY_NAME = 1'b1;

    localparam int ITEMS         = 220;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 64;

    localparam logic [rbs_pkg::NAME_W-1:0] NAME_POOL [4] = '{
        64'h0000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'h414C_4900_0000_0000,
        64'h414C_4900_0000_0001
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   errors;
    int   pending;
    int   send_idle;
    int   recv_stall;
    int   idle_cycles;
    int   stored;

    rbs_in_if  rec_ch ();
    rbs_out_if sorted_ch ();

    record_bubble_sort_by_key dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rec       (rec_ch),
        .sorted    (sorted_ch)
    );

    record_bubble_sort_by_key_checker sort_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .rec_mon    (rec_ch),
        .sorted_mon (sorted_ch),
        .errors     (errors),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        sorted_ch.ready <= ($urandom_range(99) >= recv_stall);

    always @(posedge clk)
    begin
        if (!rst_n || (rec_ch.valid && rec_ch.ready) || (sorted_ch.valid && sorted_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("record_bubble_sort_by_key_tb failed");
            $finish;
        end
    end

    task automatic push_record(input logic [rbs_pkg::TAG_W-1:0] tag,
                               input logic [rbs_pkg::AGE_W-1:0] age,
                               input logic [rbs_pkg::NAME_W-1:0] name, input logic last);
        while ($urandom_range(99) < send_idle)
        begin
            rec_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rec_ch.valid <= 1'b1;
        rec_ch.record_tag <= tag;
        rec_ch.age_key <= age;
        rec_ch.name_key <= name;
        rec_ch.last_record <= last;
        @(posedge clk);
        while (!rec_ch.ready)
            @(posedge clk);
        if (!last)
            stored++;
    endtask

    // hold the request side until every sorted record is out
    task automatic drain();
        rec_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_mode(input bit mode);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_set(input int n);
        logic [rbs_pkg::AGE_W-1:0]  age;
        logic [rbs_pkg::NAME_W-1:0] name;
        int                         len;
        int                         k;
        int                         b;
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(3))
                0:       age = '0;
                1:       age = '1;
                2:       age = rbs_pkg::AGE_W'($urandom_range(3));
                default: age = rbs_pkg::AGE_W'($urandom_range(127));
            endcase
            case ($urandom_range(3))
                0:       name = {$urandom, $urandom};
                1:       name = NAME_POOL[$urandom_range(3)];
                default:
                begin
                    name = '0;
                    len = $urandom_range(8);
                    for (b = 0; b < len; b++)
                        name[rbs_pkg::NAME_W - 1 - 8 * b -: 8] = 8'($urandom_range(97, 99));
                end
            endcase
            push_record(rbs_pkg::TAG_W'($urandom_range(255)), age, name, k == n - 1);
        end
        if (n <= rbs_pkg::MAX_RECORDS)
            stored++;
    endtask

    initial
    begin
        int phase;
        int r;
        int n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        rec_ch.valid = 1'b0;
        rec_ch.record_tag = '0;
        rec_ch.age_key = '0;
        rec_ch.name_key = '0;
        rec_ch.last_record = 1'b0;
        sorted_ch.ready = 1'b0;
        send_idle = 0;
        recv_stall = 0;
        idle_cycles = 0;
        stored = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_record(8'hFF, 7'h7F, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);

        push_record(8'h10, 7'h7F, 64'h0, 1'b0);
        push_record(8'h11, 7'h00, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_record(8'h12, 7'h40, 64'h0, 1'b0);
        push_record(8'h13, 7'h00, 64'h0, 1'b0);
        push_record(8'h14, 7'h7F, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);

        set_mode(BY_NAME);
        push_record(8'h20, 7'h00, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_record(8'h21, 7'h7F, 64'h0, 1'b0);
        push_record(8'h22, 7'h05, 64'h4142_0000_0000_0000, 1'b0);
        push_record(8'h23, 7'h06, 64'h4142_0000_0000_0000, 1'b0);
        push_record(8'h24, 7'h07, 64'h4142_4300_0000_0000, 1'b1);
        push_record(8'h00, 7'h00, NAME_POOL[2], 1'b0);
        push_record(8'hFF, 7'h7F, NAME_POOL[2], 1'b1);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle = 57;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle = 0;
                    recv_stall = 57;
                end
                default:
                begin
                    send_idle = 14;
                    recv_stall = 14;
                end
            endcase
            set_mode(phase[0] ? BY_NAME : BY_AGE);
            if (phase == 0)
                send_random_set(rbs_pkg::MAX_RECORDS + 2);
            if (phase == 2)
                send_random_set(rbs_pkg::MAX_RECORDS);
            while (stored < (phase + 1) * ITEMS / 4)
            begin
                r = $urandom_range(99);
                if (r < 70)
                    n = $urandom_range(1, 6);
                else if (r < 90)
                    n = $urandom_range(7, 12);
                else if (r < 95)
                    n = rbs_pkg::MAX_RECORDS;
                else
                    n = $urandom_range(rbs_pkg::MAX_RECORDS + 1, rbs_pkg::MAX_RECORDS + 4);
                send_random_set(n);
                if ($urandom_range(9) == 0)
                    drain();
                if ($urandom_range(14) == 0)
                    set_mode(1'($urandom_range(1)));
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("record_bubble_sort_by_key_tb passed");
        else
            $display("record_bubble_sort_by_key_tb failed");
        $finish;
    end

endmodule

[record_bubble_sort_by_key.f]
sv/rbs_pkg.sv
sv/rbs_in_if.sv
sv/rbs_out_if.sv
sv/record_bubble_sort_by_key.sv
verif/record_bubble_sort_by_key_checker.sv
verif/record_bubble_sort_by_key_tb.sv
